@@ design/reader_writer_lock_table_top_assert.svh @@
// Assertion macros used by the lock table RTL.
`ifndef READER_WRITER_LOCK_TABLE_TOP_ASSERT_SVH
`define READER_WRITER_LOCK_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RWLT_CHK_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RWLT_CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rwlt_pkg.sv @@
`timescale 1ns / 1ps
package rwlt_pkg;

   typedef enum logic [2:0] {
      OP_CHECK_FREE    = 3'd0,
      OP_READ_ACQUIRE  = 3'd1,
      OP_READ_RELEASE  = 3'd2,
      OP_WRITE_ACQUIRE = 3'd3,
      OP_WRITE_RELEASE = 3'd4,
      OP_STATUS        = 3'd5
   } op_type;

   localparam int OP_W    = 3;
   localparam int SLOT_W  = 4;
   localparam int ENTRY_W = 8;

   localparam logic [ENTRY_W-1:0] READER_MAX = 8'd127;
   localparam logic [ENTRY_W-1:0] WRITER_BIT = 8'd128;
   localparam logic [ENTRY_W-1:0] REFUSED    = 8'hFF;
   localparam logic [ENTRY_W-1:0] SUCCESS    = 8'd0;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic               wr_en;
      logic [ENTRY_W-1:0] wr_data;
      logic [ENTRY_W-1:0] reply;
   } upd_type;

endpackage

@@ design/rwlt_req_reg.sv @@
`timescale 1ns / 1ps
module rwlt_req_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rwlt_pkg::OP_W-1:0]     operation,
   input  logic [rwlt_pkg::SLOT_W-1:0]   slot,
   output logic                          req_valid,
   output rwlt_pkg::req_type             req
);
   import rwlt_pkg::*;

   logic    valid_ff, valid_in;
   req_type req_ff, req_in;

   always_comb begin
      valid_in = accept;
      req_in   = accept ? req_type'{op: operation, slot: slot} : req_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign req_valid = valid_ff;
   assign req       = req_ff;

endmodule

@@ design/rwlt_entry_alu.sv @@
`timescale 1ns / 1ps
module rwlt_entry_alu (
   input  logic                          in_range,
   input  rwlt_pkg::req_type             req,
   input  logic [rwlt_pkg::ENTRY_W-1:0]  entry,
   output rwlt_pkg::upd_type             upd
);
   import rwlt_pkg::*;

   logic [ENTRY_W-1:0] dec;

   assign dec = entry - 8'd1;

   always_comb begin
      upd = '{wr_en: 1'b0, wr_data: entry, reply: REFUSED};
      if (in_range) begin
         unique case (op_type'(req.op))
            OP_CHECK_FREE: begin
               if (entry == '0) upd.reply = {4'b0, req.slot};
            end
            OP_READ_ACQUIRE: begin
               if (entry <= READER_MAX) begin
                  // count saturates at the reader limit
                  upd.wr_data = (entry == READER_MAX) ? entry : entry + 8'd1;
                  upd.wr_en   = 1'b1;
                  upd.reply   = upd.wr_data;
               end
            end
            OP_READ_RELEASE: begin
               if (entry != '0 && entry != WRITER_BIT) begin
                  upd.wr_en   = 1'b1;
                  upd.wr_data = dec;
                  upd.reply   = dec & READER_MAX;
               end
            end
            OP_WRITE_ACQUIRE: begin
               if (entry == '0) begin
                  upd.wr_en   = 1'b1;
                  upd.wr_data = WRITER_BIT;
                  upd.reply   = SUCCESS;
               end
            end
            OP_WRITE_RELEASE: begin
               if (entry[ENTRY_W-1]) begin
                  upd.wr_en   = 1'b1;
                  upd.wr_data = entry - WRITER_BIT;
                  upd.reply   = SUCCESS;
               end
            end
            OP_STATUS: begin
               if (!entry[ENTRY_W-1]) upd.reply = entry;
            end
            default: begin
               upd.reply = REFUSED;
            end
         endcase
      end
   end

endmodule

@@ design/rwlt_table.sv @@
`timescale 1ns / 1ps
module rwlt_table #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  rwlt_pkg::req_type             req,
   output logic                          rsp_strobe,
   output logic [rwlt_pkg::ENTRY_W-1:0]  rsp_reply
);
   import rwlt_pkg::*;
`include "reader_writer_lock_table_top_assert.svh"

   // only slots reachable through the 4-bit slot field get storage
   localparam int DEPTH = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ENTRY_W-1:0] SLOTS_LIM = ENTRY_W'(SLOTS);

   logic [ENTRY_W-1:0] table_ff [DEPTH];
   logic [ENTRY_W-1:0] entry;
   logic [IDX_W-1:0]   idx;
   logic               in_range;
   upd_type            upd;

   logic               strobe_ff, strobe_in;
   logic [ENTRY_W-1:0] reply_ff, reply_in;

   assign in_range = ({4'b0, req.slot} < SLOTS_LIM);
   assign idx      = req.slot[IDX_W-1:0];
   assign entry    = in_range ? table_ff[idx] : '0;

   rwlt_entry_alu u_alu (
      .in_range (in_range),
      .req      (req),
      .entry    (entry),
      .upd      (upd)
   );

   assign strobe_in = req_valid;
   assign reply_in  = upd.reply;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) table_ff[i] <= '0;
      end else if (req_valid && upd.wr_en) begin
         table_ff[idx] <= upd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_ff <= reply_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_reply  = reply_ff;

   `RWLT_CHK_NEXT(a_rsp_follows_req, clock, reset, req_valid, rsp_strobe, "missing response")
   `RWLT_CHK_SAME(a_no_write_out_of_range, clock, reset, upd.wr_en, in_range,
      "write to absent slot")
   `RWLT_CHK_SAME(a_entry_legal, clock, reset, req_valid && upd.wr_en,
      upd.wr_data <= WRITER_BIT, "writer and readers together")
   `RWLT_CHK_NEXT(a_range_refused, clock, reset, req_valid && !in_range,
      rsp_reply == REFUSED, "slot out of range not refused")
   `RWLT_CHK_NEXT(a_wacq_success, clock, reset,
      req_valid && upd.wr_en && upd.wr_data == WRITER_BIT,
      rsp_reply == SUCCESS, "write acquire reply not zero")

endmodule

@@ design/reader_writer_lock_table_top.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                    Transfer
// request   start, busy, req_operation, req_slot     start high and busy low at clock edge
// response  rsp_strobe, rsp_reply                    rsp_strobe high for one cycle
//
// One request per cycle; busy stays low.
// A response reaches the ports from the reply register: the entry
// read-modify-write runs while the request sits in the request register, and
// its result lands in the reply register, which drives the ports.
// Synchronous reset clears every lock entry at once; no clearing pass.
// The receiver cannot stall; each response is shown for exactly one cycle.
module reader_writer_lock_table_top #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rwlt_pkg::OP_W-1:0]     req_operation,
   input  logic [rwlt_pkg::SLOT_W-1:0]   req_slot,
   output logic                          rsp_strobe,
   output logic [rwlt_pkg::ENTRY_W-1:0]  rsp_reply
);
   import rwlt_pkg::*;

   logic    accept;
   logic    req_valid;
   req_type req;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   rwlt_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .slot      (req_slot),
      .req_valid (req_valid),
      .req       (req)
   );

   rwlt_table #(
      .SLOTS (SLOTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp_reply  (rsp_reply)
   );

endmodule
